/* rtl/afc_pkg.sv */
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and constants of the animated frame compositor: request and
// result structs, opcodes, disposal codes and register indexes.
// ----------------------------------------------------------------------------
package afc_pkg;

    // Default sizes of the canvas and of the two pixel stores.
    localparam int AFC_MAX_DIM       = 256;
    localparam int AFC_CANVAS_PIXELS = 65536;

    // Configuration port widths.
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

    // Request opcodes.
    localparam logic [1:0] OP_HEADER = 2'd0;
    localparam logic [1:0] OP_PIXEL  = 2'd1;
    localparam logic [1:0] OP_EOF    = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // Disposal codes that do something; all others keep the canvas.
    localparam logic [2:0] DISP_CLEAR   = 3'd2;
    localparam logic [2:0] DISP_RESTORE = 3'd3;

    // Delay handling in milliseconds.
    localparam logic [19:0] DELAY_DEFAULT_MS = 20'd100;
    localparam logic [19:0] DELAY_MIN_MS     = 20'd20;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] frame_left;
        logic [15:0] frame_top;
        logic [15:0] frame_cols;
        logic [15:0] frame_rows;
        logic [2:0]  dispose_mode;
        logic [15:0] delay_centis;
        logic [7:0]  src_blue;
        logic [7:0]  src_green;
        logic [7:0]  src_red;
        logic [7:0]  src_alpha;
        logic [15:0] read_index;
    } afc_req_t;

    typedef struct packed {
        logic [7:0]  out_blue;
        logic [7:0]  out_green;
        logic [7:0]  out_red;
        logic [7:0]  out_alpha;
        logic [19:0] delay_ms;
        logic        pixel_dropped;
        logic        read_ok;
    } afc_result_t;

    // Result of a request that returns nothing in particular.
    localparam afc_result_t AFC_RESULT_NONE = '{
        out_blue:      8'd0,
        out_green:     8'd0,
        out_red:       8'd0,
        out_alpha:     8'd0,
        delay_ms:      DELAY_DEFAULT_MS,
        pixel_dropped: 1'b0,
        read_ok:       1'b0
    };

endpackage

/* rtl/animated_frame_compositor.sv */
// ----------------------------------------------------------------------------
// animated_frame_compositor
// Composites animation frames onto a canvas of premultiplied BGRA pixels
// held in a synchronous memory, with a second memory for the snapshot used
// by the restore-previous disposal.
//
//   channel   ports                         handshake
//   -------   ---------------------------   -------------------------------
//   request   start, busy, req              taken when start && !busy && !cfg_we
//   result    done, result                  one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_index, cfg_data   written when cfg_we is high while idle
//
// A header, a dropped pixel and an end of frame give their result straight from
// idle; a read passes through ST_RD; a pixel inside the canvas goes through
// address, memory read, blend multiply and write back. A header with restore
// disposal then copies the canvas, and an end of frame with restore copies it
// back, one memory entry per cycle. A clear disposal walks the clipped frame
// rectangle at one pixel per cycle.
// After reset and after every configuration write a clearing pass zeroes
// both memories; busy stays high meanwhile.
// The receiver cannot stall; done is high for a single cycle with each result.
// ----------------------------------------------------------------------------
module animated_frame_compositor #(
    parameter int MAX_DIM       = afc_pkg::AFC_MAX_DIM,
    parameter int CANVAS_PIXELS = afc_pkg::AFC_CANVAS_PIXELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  afc_pkg::afc_req_t                 req,
    output logic                              done,
    output afc_pkg::afc_result_t              result,
    input  logic                              cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import afc_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int AW    = $clog2(CANVAS_PIXELS);
    localparam int CNT_W = AW + 1;
    localparam int PW    = 2 * DIM_W;
    localparam int DIM_RESET = (MAX_DIM < 256) ? MAX_DIM : 256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PIX_ADDR,
        ST_PIX_MUL,
        ST_PIX_WR,
        ST_RD,
        ST_SNAP,
        ST_RESTORE,
        ST_RECT
    } state_t;

    // Written dimension, with zero taken as one and large values limited.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [31:0] d;
        d = 32'(v);
        if (d == 32'd0)
        begin
            d = 32'd1;
        end
        if (d > 32'(MAX_DIM))
        begin
            d = 32'(MAX_DIM);
        end
        return d[DIM_W-1:0];
    endfunction

    // Exact floor(p / 255) for products of two 8-bit values.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = 17'(p) + 17'(p[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    // Memories and their read data registers.
    logic [31:0]   canvas_mem [CANVAS_PIXELS];
    logic [31:0]   snapshot_mem [CANVAS_PIXELS];
    logic [31:0]   c_rdata_reg;
    logic [31:0]   s_rdata_reg;
    logic          c_we;
    logic [AW-1:0] c_waddr;
    logic [31:0]   c_wdata;
    logic [AW-1:0] c_raddr;
    logic          s_we;
    logic [AW-1:0] s_waddr;
    logic [31:0]   s_wdata;
    logic [AW-1:0] s_raddr;

    // Control and payload registers.
    state_t            state_reg, state_next;
    logic [DIM_W-1:0]  canvas_w_reg, canvas_w_next;
    logic [DIM_W-1:0]  canvas_h_reg, canvas_h_next;
    logic [15:0]       cur_left_reg, cur_left_next;
    logic [15:0]       cur_top_reg, cur_top_next;
    logic [15:0]       cur_cols_reg, cur_cols_next;
    logic [15:0]       cur_rows_reg, cur_rows_next;
    logic [2:0]        cur_dispose_reg, cur_dispose_next;
    logic [15:0]       pixel_col_reg, pixel_col_next;
    logic [15:0]       pixel_row_reg, pixel_row_next;
    logic [CNT_W-1:0]  walk_reg, walk_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [DIM_W-1:0]  cx_reg, cx_next;
    logic [DIM_W-1:0]  cy_reg, cy_next;
    logic [DIM_W-1:0]  x_start_reg, x_start_next;
    logic [DIM_W-1:0]  x_lim_reg, x_lim_next;
    logic [DIM_W-1:0]  y_lim_reg, y_lim_next;
    logic [DIM_W-1:0]  pix_x_reg, pix_x_next;
    logic [DIM_W-1:0]  pix_y_reg, pix_y_next;
    logic [AW-1:0]     pix_addr_reg, pix_addr_next;
    logic [31:0]       src_reg, src_next;
    logic [15:0]       prod_b_reg, prod_b_next;
    logic [15:0]       prod_g_reg, prod_g_next;
    logic [15:0]       prod_r_reg, prod_r_next;
    logic [15:0]       prod_a_reg, prod_a_next;
    afc_result_t       result_reg, result_next;
    logic              done_reg, done_next;

    // Combinational helpers.
    logic [19:0]  delay_c;
    logic [16:0]  pos_x;
    logic [16:0]  pos_y;
    logic [16:0]  rect_xe;
    logic [16:0]  rect_ye;
    logic [16:0]  rect_xl;
    logic [16:0]  rect_yl;
    logic         rect_empty;
    logic [PW:0]  pix_lin;
    logic [PW:0]  rect_lin;
    logic [PW-1:0] area;
    logic         read_in;
    logic [DIM_W:0] cx_inc;
    logic [DIM_W:0] cy_inc;
    logic [7:0]   inv_alpha;
    logic [31:0]  blend_word;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Address, limit, delay and blend arithmetic shared by the states below.
    always_comb
    begin
        delay_c    = ({4'd0, req.delay_centis} << 3) + ({4'd0, req.delay_centis} << 1);
        pos_x      = {1'b0, cur_left_reg} + {1'b0, pixel_col_reg};
        pos_y      = {1'b0, cur_top_reg} + {1'b0, pixel_row_reg};
        rect_xe    = {1'b0, cur_left_reg} + {1'b0, cur_cols_reg};
        rect_ye    = {1'b0, cur_top_reg} + {1'b0, cur_rows_reg};
        rect_xl    = (rect_xe < 17'(canvas_w_reg)) ? rect_xe : 17'(canvas_w_reg);
        rect_yl    = (rect_ye < 17'(canvas_h_reg)) ? rect_ye : 17'(canvas_h_reg);
        rect_empty = (17'(cur_left_reg) >= 17'(canvas_w_reg))
                  || (17'(cur_top_reg) >= 17'(canvas_h_reg))
                  || (cur_cols_reg == 16'd0) || (cur_rows_reg == 16'd0);
        pix_lin    = (PW+1)'(pix_y_reg) * (PW+1)'(canvas_w_reg) + (PW+1)'(pix_x_reg);
        rect_lin   = (PW+1)'(cy_reg) * (PW+1)'(canvas_w_reg) + (PW+1)'(cx_reg);
        area       = PW'(canvas_w_reg) * PW'(canvas_h_reg);
        read_in    = (32'(req.read_index) < 32'(area))
                  && (32'(req.read_index) < 32'(CANVAS_PIXELS));
        cx_inc     = {1'b0, cx_reg} + (DIM_W+1)'(1);
        cy_inc     = {1'b0, cy_reg} + (DIM_W+1)'(1);
        inv_alpha  = ALPHA_OPAQUE - src_reg[31:24];
        blend_word = {src_reg[31:24] + div255(prod_a_reg),
                      src_reg[23:16] + div255(prod_r_reg),
                      src_reg[15:8]  + div255(prod_g_reg),
                      src_reg[7:0]   + div255(prod_b_reg)};
    end

    // Sequencer: next state, memory ports and the result.
    always_comb
    begin
        state_next       = state_reg;
        canvas_w_next    = canvas_w_reg;
        canvas_h_next    = canvas_h_reg;
        cur_left_next    = cur_left_reg;
        cur_top_next     = cur_top_reg;
        cur_cols_next    = cur_cols_reg;
        cur_rows_next    = cur_rows_reg;
        cur_dispose_next = cur_dispose_reg;
        pixel_col_next   = pixel_col_reg;
        pixel_row_next   = pixel_row_reg;
        walk_next        = walk_reg;
        pend_next        = pend_reg;
        pend_addr_next   = pend_addr_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        x_start_next     = x_start_reg;
        x_lim_next       = x_lim_reg;
        y_lim_next       = y_lim_reg;
        pix_x_next       = pix_x_reg;
        pix_y_next       = pix_y_reg;
        pix_addr_next    = pix_addr_reg;
        src_next         = src_reg;
        prod_b_next      = prod_b_reg;
        prod_g_next      = prod_g_reg;
        prod_r_next      = prod_r_reg;
        prod_a_next      = prod_a_reg;
        result_next      = result_reg;
        done_next        = 1'b0;
        c_we    = 1'b0;
        c_waddr = pix_addr_reg;
        c_wdata = 32'd0;
        c_raddr = AW'(req.read_index);
        s_we    = 1'b0;
        s_waddr = pend_addr_reg;
        s_wdata = c_rdata_reg;
        s_raddr = walk_reg[AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                c_we      = 1'b1;
                s_we      = 1'b1;
                c_waddr   = walk_reg[AW-1:0];
                s_waddr   = walk_reg[AW-1:0];
                s_wdata   = 32'd0;
                walk_next = walk_reg + CNT_W'(1);
                if (walk_reg == CNT_W'(CANVAS_PIXELS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    // Any dimension write clears both stores.
                    if (cfg_index == REG_CANVAS_WIDTH)
                    begin
                        canvas_w_next = clamp_dim(cfg_data);
                    end
                    else
                    begin
                        canvas_h_next = clamp_dim(cfg_data);
                    end
                    walk_next  = '0;
                    state_next = ST_CLEAR;
                end
                else if (start)
                begin
                    unique case (req.opcode)
                        OP_HEADER:
                        begin
                            cur_left_next    = req.frame_left;
                            cur_top_next     = req.frame_top;
                            cur_cols_next    = req.frame_cols;
                            cur_rows_next    = req.frame_rows;
                            cur_dispose_next = req.dispose_mode;
                            pixel_col_next   = 16'd0;
                            pixel_row_next   = 16'd0;
                            result_next      = AFC_RESULT_NONE;
                            result_next.delay_ms =
                                (delay_c < DELAY_MIN_MS) ? DELAY_DEFAULT_MS : delay_c;
                            done_next = 1'b1;
                            if (req.dispose_mode == DISP_RESTORE)
                            begin
                                walk_next  = '0;
                                pend_next  = 1'b0;
                                state_next = ST_SNAP;
                            end
                        end

                        OP_PIXEL:
                        begin
                            result_next = AFC_RESULT_NONE;
                            if ((pixel_row_reg >= cur_rows_reg)
                                || (pixel_col_reg >= cur_cols_reg))
                            begin
                                result_next.pixel_dropped = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                // Raster position advances even when clipped.
                                if (pixel_col_reg + 16'd1 >= cur_cols_reg)
                                begin
                                    pixel_col_next = 16'd0;
                                    pixel_row_next = pixel_row_reg + 16'd1;
                                end
                                else
                                begin
                                    pixel_col_next = pixel_col_reg + 16'd1;
                                end
                                if ((pos_x < 17'(canvas_w_reg)) && (pos_y < 17'(canvas_h_reg)))
                                begin
                                    pix_x_next = pos_x[DIM_W-1:0];
                                    pix_y_next = pos_y[DIM_W-1:0];
                                    src_next   = {req.src_alpha, req.src_red,
                                                  req.src_green, req.src_blue};
                                    state_next = ST_PIX_ADDR;
                                end
                                else
                                begin
                                    result_next.pixel_dropped = 1'b1;
                                    done_next = 1'b1;
                                end
                            end
                        end

                        OP_EOF:
                        begin
                            result_next = AFC_RESULT_NONE;
                            done_next   = 1'b1;
                            if ((cur_dispose_reg == DISP_CLEAR) && !rect_empty)
                            begin
                                cx_next      = cur_left_reg[DIM_W-1:0];
                                cy_next      = cur_top_reg[DIM_W-1:0];
                                x_start_next = cur_left_reg[DIM_W-1:0];
                                x_lim_next   = rect_xl[DIM_W-1:0];
                                y_lim_next   = rect_yl[DIM_W-1:0];
                                state_next   = ST_RECT;
                            end
                            else if (cur_dispose_reg == DISP_RESTORE)
                            begin
                                walk_next  = '0;
                                pend_next  = 1'b0;
                                state_next = ST_RESTORE;
                            end
                        end

                        OP_READ:
                        begin
                            // Memory read is issued now through c_raddr.
                            if (read_in)
                            begin
                                state_next = ST_RD;
                            end
                            else
                            begin
                                result_next = AFC_RESULT_NONE;
                                done_next   = 1'b1;
                            end
                        end

                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_PIX_ADDR:
            begin
                if (32'(pix_lin) < 32'(CANVAS_PIXELS))
                begin
                    c_raddr       = AW'(pix_lin);
                    pix_addr_next = AW'(pix_lin);
                    state_next    = ST_PIX_MUL;
                end
                else
                begin
                    result_next = AFC_RESULT_NONE;
                    result_next.pixel_dropped = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_PIX_MUL:
            begin
                // Destination weighted by the inverse source alpha.
                prod_b_next = 16'(c_rdata_reg[7:0])   * 16'(inv_alpha);
                prod_g_next = 16'(c_rdata_reg[15:8])  * 16'(inv_alpha);
                prod_r_next = 16'(c_rdata_reg[23:16]) * 16'(inv_alpha);
                prod_a_next = 16'(c_rdata_reg[31:24]) * 16'(inv_alpha);
                state_next  = ST_PIX_WR;
            end

            ST_PIX_WR:
            begin
                if (src_reg[31:24] == ALPHA_OPAQUE)
                begin
                    c_we    = 1'b1;
                    c_wdata = {ALPHA_OPAQUE, src_reg[23:0]};
                end
                else if (src_reg[31:24] != 8'd0)
                begin
                    c_we    = 1'b1;
                    c_wdata = blend_word;
                end
                result_next = AFC_RESULT_NONE;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end

            ST_RD:
            begin
                result_next           = AFC_RESULT_NONE;
                result_next.out_blue  = c_rdata_reg[7:0];
                result_next.out_green = c_rdata_reg[15:8];
                result_next.out_red   = c_rdata_reg[23:16];
                result_next.out_alpha = c_rdata_reg[31:24];
                result_next.read_ok   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_SNAP, ST_RESTORE:
            begin
                // Read one entry per cycle and write it to the other store in the next cycle.
                c_raddr = walk_reg[AW-1:0];
                if (walk_reg < CNT_W'(CANVAS_PIXELS))
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = walk_reg[AW-1:0];
                    walk_next      = walk_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (state_reg == ST_SNAP)
                    begin
                        s_we = 1'b1;
                    end
                    else
                    begin
                        c_we    = 1'b1;
                        c_waddr = pend_addr_reg;
                        c_wdata = s_rdata_reg;
                    end
                end
                if ((walk_reg == CNT_W'(CANVAS_PIXELS)) && !pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_RECT:
            begin
                // Zero the clipped frame rectangle one pixel per cycle.
                if (32'(rect_lin) < 32'(CANVAS_PIXELS))
                begin
                    c_we    = 1'b1;
                    c_waddr = AW'(rect_lin);
                    c_wdata = 32'd0;
                end
                if (cx_inc < {1'b0, x_lim_reg})
                begin
                    cx_next = cx_inc[DIM_W-1:0];
                end
                else
                begin
                    cx_next = x_start_reg;
                    cy_next = cy_inc[DIM_W-1:0];
                    if (cy_inc >= {1'b0, y_lim_reg})
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            canvas_w_reg    <= DIM_W'(DIM_RESET);
            canvas_h_reg    <= DIM_W'(DIM_RESET);
            cur_left_reg    <= '0;
            cur_top_reg     <= '0;
            cur_cols_reg    <= '0;
            cur_rows_reg    <= '0;
            cur_dispose_reg <= '0;
            pixel_col_reg   <= '0;
            pixel_row_reg   <= '0;
            walk_reg        <= '0;
            pend_reg        <= 1'b0;
            pend_addr_reg   <= '0;
            cx_reg          <= '0;
            cy_reg          <= '0;
            x_start_reg     <= '0;
            x_lim_reg       <= '0;
            y_lim_reg       <= '0;
            pix_x_reg       <= '0;
            pix_y_reg       <= '0;
            pix_addr_reg    <= '0;
            src_reg         <= '0;
            prod_b_reg      <= '0;
            prod_g_reg      <= '0;
            prod_r_reg      <= '0;
            prod_a_reg      <= '0;
            result_reg      <= AFC_RESULT_NONE;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            canvas_w_reg    <= canvas_w_next;
            canvas_h_reg    <= canvas_h_next;
            cur_left_reg    <= cur_left_next;
            cur_top_reg     <= cur_top_next;
            cur_cols_reg    <= cur_cols_next;
            cur_rows_reg    <= cur_rows_next;
            cur_dispose_reg <= cur_dispose_next;
            pixel_col_reg   <= pixel_col_next;
            pixel_row_reg   <= pixel_row_next;
            walk_reg        <= walk_next;
            pend_reg        <= pend_next;
            pend_addr_reg   <= pend_addr_next;
            cx_reg          <= cx_next;
            cy_reg          <= cy_next;
            x_start_reg     <= x_start_next;
            x_lim_reg       <= x_lim_next;
            y_lim_reg       <= y_lim_next;
            pix_x_reg       <= pix_x_next;
            pix_y_reg       <= pix_y_next;
            pix_addr_reg    <= pix_addr_next;
            src_reg         <= src_next;
            prod_b_reg      <= prod_b_next;
            prod_g_reg      <= prod_g_next;
            prod_r_reg      <= prod_r_next;
            prod_a_reg      <= prod_a_next;
            result_reg      <= result_next;
            done_reg        <= done_next;
        end
    end

    // Canvas memory.
    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            canvas_mem[c_waddr] <= c_wdata;
        end
        c_rdata_reg <= canvas_mem[c_raddr];
    end

    // Snapshot memory.
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            snapshot_mem[s_waddr] <= s_wdata;
        end
        s_rdata_reg <= snapshot_mem[s_raddr];
    end

    // Both memories are written together only by the clearing pass.
    a_dual_write_only_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (c_we && s_we) |-> (state_reg == ST_CLEAR))
        else $error("both stores written outside the clearing pass");

    // The blend write back always ends the pixel with a result.
    a_pixel_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PIX_WR) |=> (done_reg && !busy))
        else $error("pixel write back gave no result");

    // A read inside the canvas returns its pixel in the cycle after ST_RD.
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |=> (done_reg && result_reg.read_ok))
        else $error("canvas read gave no valid result");

    // A pending copy write exists only during a copy sweep.
    a_pend_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ((state_reg == ST_SNAP) || (state_reg == ST_RESTORE)))
        else $error("copy write pending outside a copy sweep");

endmodule
